[src/gbg_pkg.sv]
// Gradient bar gauge renderer: shared types and constants.
// Used by every module of the block but gbg_div; depends on nothing.
package gbg_pkg;

    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned SIZE_W     = 6;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned GAP_W      = 5;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned PROD_W     = LEVEL_W + SIZE_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned S_DATA_W   = 80;
    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QAW        = 1;

    localparam logic [LEVEL_W-1:0] DEFAULT_FULL_SCALE = 16'h03ff;
    localparam logic [COLOR_W-1:0] GAP_COLOR          = 24'h000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE,
        CFG_GAP_PIXELS,
        CFG_BACKGROUND,
        CFG_GAUGE_COUNT
    } cfg_index_t;

    typedef enum logic {
        CMD_DEFINE,
        CMD_RENDER
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] full_scale;
        logic [GAP_W-1:0]   gap_pixels;
        logic [COLOR_W-1:0] background_color;
        logic [COUNT_W-1:0] gauge_count;
    } cfg_t;

    // one render job, colors already swapped for reverse gauges
    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [COLOR_W-1:0] first;
        logic [COLOR_W-1:0] last;
        logic               rev;
        logic [LEVEL_W-1:0] level;
        logic               gap;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_START,
        B_DIV,
        B_PREP,
        B_PIX,
        B_GAP
    } back_state_t;

endpackage

[src/gbg_div.sv]
// Restoring divider, one quotient bit per cycle over the DW-bit dividend.
// Uses no package items.
module gbg_div #(
    parameter int DW = 22,
    parameter int VW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          busy
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   trial;
    logic          fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[DW-1]};
        fits     = trial >= {1'b0, dvs_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start) begin
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end else if (cnt_reg != '0) begin
            rem_next = fits ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign busy     = cnt_reg != '0;

endmodule

[src/gbg_front.sv]
// Front end: accepts items, keeps the gauge table, turns renders into jobs.
// Depends on gbg_pkg.
module gbg_front #(
    parameter int MAX_GAUGES       = 8,
    parameter int MAX_GAUGE_PIXELS = 32
) (
    input  logic                               aclk,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gbg_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                               s_tuser,
    input  logic [gbg_pkg::COUNT_W-1:0]        gauge_count,
    input  logic                               q_full,
    output logic                               q_push,
    output gbg_pkg::job_t                      q_job
);

    localparam int TAB_DEPTH = (MAX_GAUGES < 8) ? MAX_GAUGES : 8;
    localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

    logic [gbg_pkg::SIZE_W-1:0]  size_tab  [TAB_DEPTH];
    logic [gbg_pkg::COLOR_W-1:0] start_tab [TAB_DEPTH];
    logic [gbg_pkg::COLOR_W-1:0] end_tab   [TAB_DEPTH];
    logic                        rev_tab   [TAB_DEPTH];

    gbg_pkg::cmd_t               cmd;
    logic [gbg_pkg::IDX_W-1:0]   idx;
    logic [gbg_pkg::SIZE_W-1:0]  in_size;
    logic [gbg_pkg::COLOR_W-1:0] in_start;
    logic [gbg_pkg::COLOR_W-1:0] in_end;
    logic                        in_rev;
    logic [gbg_pkg::LEVEL_W-1:0] in_level;
    logic                        take;
    logic                        idx_ok;
    logic                        wr_en;
    logic [TAB_AW-1:0]           addr;
    logic [gbg_pkg::SIZE_W-1:0]  tab_size;
    logic                        tab_rev;

    always_comb begin
        cmd      = gbg_pkg::cmd_t'(s_tuser);
        idx      = s_tdata[2:0];
        in_size  = s_tdata[8:3];
        in_start = s_tdata[32:9];
        in_end   = s_tdata[56:33];
        in_rev   = s_tdata[57];
        in_level = s_tdata[73:58];
        s_tready = !q_full;
        take     = s_tvalid && s_tready;
        idx_ok   = {29'd0, idx} < 32'(MAX_GAUGES);
        addr     = idx[TAB_AW-1:0];
        wr_en    = take && idx_ok && (cmd == gbg_pkg::CMD_DEFINE);
        q_push   = take && idx_ok && (cmd == gbg_pkg::CMD_RENDER);

        tab_size = size_tab[addr];
        tab_rev  = rev_tab[addr];
        if ({2'b00, tab_size} > 8'(MAX_GAUGE_PIXELS)) begin
            q_job.size = gbg_pkg::SIZE_W'(MAX_GAUGE_PIXELS);
        end else begin
            q_job.size = tab_size;
        end
        q_job.first = tab_rev ? end_tab[addr] : start_tab[addr];
        q_job.last  = tab_rev ? start_tab[addr] : end_tab[addr];
        q_job.rev   = tab_rev;
        q_job.level = in_level;
        q_job.gap   = ({1'b0, idx} + 4'd1) < gauge_count;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            size_tab[addr]  <= in_size;
            start_tab[addr] <= in_start;
            end_tab[addr]   <= in_end;
            rev_tab[addr]   <= in_rev;
        end
    end

endmodule

[src/gbg_fifo.sv]
// Two-entry job queue between the front end and the pixel engine.
// Depends on gbg_pkg.
module gbg_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gbg_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output gbg_pkg::job_t pop_job
);

    gbg_pkg::job_t                mem [gbg_pkg::QDEPTH];
    logic [gbg_pkg::QAW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [gbg_pkg::QAW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [gbg_pkg::QAW:0]        cnt_reg, cnt_next;

    always_comb begin
        full        = cnt_reg == (gbg_pkg::QAW + 1)'(gbg_pkg::QDEPTH);
        empty       = cnt_reg == '0;
        pop_job     = mem[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (gbg_pkg::QAW + 1)'(push) - (gbg_pkg::QAW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[src/gbg_back.sv]
// Pixel engine: scales the level, derives gradient steps, streams pixels.
// Depends on gbg_pkg and gbg_div.
module gbg_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gbg_pkg::cfg_t                     cfg,
    input  logic                              q_empty,
    input  gbg_pkg::job_t                     q_job,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gbg_pkg::COLOR_W-1:0]       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int CW = gbg_pkg::CHAN_W;

    gbg_pkg::back_state_t              state_reg, state_next;
    gbg_pkg::job_t                     job_reg;
    logic [gbg_pkg::PROD_W-1:0]        prod_reg;
    logic [2:0]                        neg_reg;
    logic [gbg_pkg::SIZE_W-1:0]        lit_reg;
    logic [2:0][CW-1:0]                offs_reg;
    logic [2:0][CW-1:0]                acc_reg;
    logic [gbg_pkg::SIZE_W-1:0]        pix_reg;
    logic [gbg_pkg::GAP_W-1:0]         gcnt_reg;
    logic                              m_tvalid_reg;
    logic [gbg_pkg::COLOR_W-1:0]       m_tdata_reg;
    logic                              m_tuser_reg;
    logic                              m_tlast_reg;

    logic                              chan_start, lit_start, emit_px, emit_gap;
    logic                              adv, gap_run, last_px, last_gap, lit_on;
    logic [gbg_pkg::LEVEL_W-1:0]       fs;
    logic [gbg_pkg::PROD_W-1:0]        lit_q;
    logic                              lit_busy;
    logic [2:0]                        chan_busy;
    logic [2:0]                        neg;
    logic [2:0][CW-1:0]                mag, chan_q, step, first_c, last_c, grad_c;
    logic [2:0][2*CW-1:0]              span;
    logic [gbg_pkg::SIZE_W-1:0]        size_m1;
    logic [gbg_pkg::COLOR_W-1:0]       grad, pixel;

    gbg_div #(.DW(gbg_pkg::PROD_W), .VW(gbg_pkg::LEVEL_W)) u_lit_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lit_start),
        .dividend (prod_reg),
        .divisor  (fs),
        .quotient (lit_q),
        .busy     (lit_busy)
    );

    for (genvar c = 0; c < 3; c++) begin : g_chan
        gbg_div #(.DW(CW), .VW(gbg_pkg::SIZE_W)) u_step_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (chan_start),
            .dividend (mag[c]),
            .divisor  (job_reg.size),
            .quotient (chan_q[c]),
            .busy     (chan_busy[c])
        );
    end

    always_comb begin
        adv      = !m_tvalid_reg || m_tready;
        gap_run  = job_reg.gap && (cfg.gap_pixels != '0);
        size_m1  = job_reg.size - gbg_pkg::SIZE_W'(1);
        last_px  = pix_reg == size_m1;
        last_gap = gcnt_reg == (cfg.gap_pixels - gbg_pkg::GAP_W'(1));
        fs       = (cfg.full_scale == '0) ? gbg_pkg::LEVEL_W'(1) : cfg.full_scale;
        for (int c = 0; c < 3; c++) begin
            first_c[c] = job_reg.first[CW*c +: CW];
            last_c[c]  = job_reg.last[CW*c +: CW];
            neg[c]     = last_c[c] < first_c[c];
            mag[c]     = neg[c] ? first_c[c] - last_c[c] : last_c[c] - first_c[c];
            step[c]    = neg_reg[c] ? CW'(-chan_q[c]) : chan_q[c];
            span[c]    = {2'b00, size_m1} * step[c];
            grad_c[c]  = (pix_reg >= (job_reg.size >> 1)) ? acc_reg[c] + offs_reg[c]
                                                            : acc_reg[c];
        end
        grad   = (pix_reg == '0) ? job_reg.first : {grad_c[2], grad_c[1], grad_c[0]};
        lit_on = job_reg.rev ? (pix_reg >= (job_reg.size - lit_reg)) : (pix_reg < lit_reg);
        pixel  = lit_on ? grad : cfg.background_color;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gbg_pkg::B_IDLE:  if (!q_empty) state_next = gbg_pkg::B_MUL;
            gbg_pkg::B_MUL:   state_next = gbg_pkg::B_START;
            gbg_pkg::B_START: state_next = gbg_pkg::B_DIV;
            gbg_pkg::B_DIV:   if (!lit_busy && (chan_busy == '0)) state_next = gbg_pkg::B_PREP;
            gbg_pkg::B_PREP: begin
                if (job_reg.size != '0) state_next = gbg_pkg::B_PIX;
                else if (gap_run)       state_next = gbg_pkg::B_GAP;
                else                    state_next = gbg_pkg::B_IDLE;
            end
            gbg_pkg::B_PIX: begin
                if (adv && last_px) state_next = gap_run ? gbg_pkg::B_GAP : gbg_pkg::B_IDLE;
            end
            gbg_pkg::B_GAP:   if (adv && last_gap) state_next = gbg_pkg::B_IDLE;
            default:          state_next = gbg_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        q_pop      = (state_reg == gbg_pkg::B_IDLE) && !q_empty;
        chan_start = state_reg == gbg_pkg::B_MUL;
        lit_start  = state_reg == gbg_pkg::B_START;
        emit_px    = (state_reg == gbg_pkg::B_PIX) && adv;
        emit_gap   = (state_reg == gbg_pkg::B_GAP) && adv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbg_pkg::B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_px || emit_gap) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end

        if (q_pop) begin
            job_reg <= q_job;
        end
        if (chan_start) begin
            prod_reg <= gbg_pkg::PROD_W'(job_reg.level * job_reg.size);
            neg_reg  <= neg;
        end
        if (state_reg == gbg_pkg::B_PREP) begin
            lit_reg  <= (lit_q > gbg_pkg::PROD_W'(job_reg.size)) ? job_reg.size
                                                                  : lit_q[gbg_pkg::SIZE_W-1:0];
            pix_reg  <= '0;
            gcnt_reg <= '0;
            for (int c = 0; c < 3; c++) begin
                offs_reg[c] <= last_c[c] - first_c[c] - span[c][CW-1:0];
                acc_reg[c]  <= first_c[c];
            end
        end
        if (emit_px) begin
            pix_reg     <= pix_reg + gbg_pkg::SIZE_W'(1);
            m_tdata_reg <= pixel;
            m_tuser_reg <= 1'b0;
            m_tlast_reg <= last_px && !gap_run;
            for (int c = 0; c < 3; c++) begin
                acc_reg[c] <= acc_reg[c] + step[c];
            end
        end
        if (emit_gap) begin
            gcnt_reg    <= gcnt_reg + gbg_pkg::GAP_W'(1);
            m_tdata_reg <= gbg_pkg::GAP_COLOR;
            m_tuser_reg <= 1'b1;
            m_tlast_reg <= last_gap;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[src/gradient_bar_gauge_renderer_core.sv]
// Gradient bar gauge renderer, top level: configuration registers and wiring.
// Depends on gbg_pkg, gbg_front, gbg_fifo, gbg_back, gbg_div.
//
// Input items arrive on s_t*. s_tuser is the command: define writes one gauge
// table entry and yields nothing; render queues a job for that gauge.
// Result items leave on m_t*, one strip pixel per item: m_tdata is the
// color, m_tuser marks a black gap pixel, m_tlast marks the final pixel.
// cfg_we/cfg_index/cfg_data write a setting; write only while
// the block is idle.
// With the engine idle, a render's item passes to its first pixel through:
// queue pop, level * size product, divider start, the 22-step bit-serial
// divide of the product by full_scale (the three channel step divides run
// alongside it), step setup, output register. Pixels then follow one per
// cycle while m_tready allows, size pixels plus gap pixels.
// Two jobs queue between the front end and the pixel engine, so items are
// taken while a render still streams. A stall on m_tready holds the output
// register and freezes the engine; the queue then fills and s_tready drops.
// Reset is synchronous: settings return to defaults, queue and engine empty.
// The gauge table is not cleared; render only gauges that were defined.
module gradient_bar_gauge_renderer_core #(
    parameter int MAX_GAUGES       = 8,
    parameter int MAX_GAUGE_PIXELS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // gauge_index, gauge_size, start_color, end_color, reverse, level
    input  logic [gbg_pkg::S_DATA_W-1:0]        s_tdata,
    // cmd
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_color
    output logic [gbg_pkg::COLOR_W-1:0]         m_tdata,
    // is_gap
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [gbg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gbg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    gbg_pkg::cfg_t cfg_reg, cfg_next;
    gbg_pkg::job_t front_job, queue_job;
    logic          q_push, q_pop, q_full, q_empty;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (gbg_pkg::cfg_index_t'(cfg_index))
                gbg_pkg::CFG_FULL_SCALE:  cfg_next.full_scale       = cfg_data[15:0];
                gbg_pkg::CFG_GAP_PIXELS:  cfg_next.gap_pixels       = cfg_data[4:0];
                gbg_pkg::CFG_BACKGROUND:  cfg_next.background_color = cfg_data;
                gbg_pkg::CFG_GAUGE_COUNT: cfg_next.gauge_count      = cfg_data[3:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_scale       <= gbg_pkg::DEFAULT_FULL_SCALE;
            cfg_reg.gap_pixels       <= '0;
            cfg_reg.background_color <= '0;
            cfg_reg.gauge_count      <= gbg_pkg::COUNT_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gbg_front #(
        .MAX_GAUGES       (MAX_GAUGES),
        .MAX_GAUGE_PIXELS (MAX_GAUGE_PIXELS)
    ) u_front (
        .aclk        (aclk),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .gauge_count (cfg_reg.gauge_count),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (front_job)
    );

    gbg_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (queue_job)
    );

    gbg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_job    (queue_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
